// ===== rtl/srra_pkg.sv =====
// Shared types and constants for the short range repulsion accumulator.
package srra_pkg;

    // Item function codes.
    typedef enum logic [1:0] {
        FUNC_BEGIN    = 2'd0,
        FUNC_LOAD     = 2'd1,
        FUNC_NEIGHBOR = 2'd2,
        FUNC_FINISH   = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SPRING_K_BASE = 3'd0;
    localparam logic [2:0] CFG_REACH_BASE    = 3'd3;
    localparam logic [2:0] CFG_END           = 3'd6;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_PREP = 10'b00_0000_0010,
        ST_SQ   = 10'b00_0000_0100,
        ST_SQRT = 10'b00_0000_1000,
        ST_CHK  = 10'b00_0001_0000,
        ST_DIVI = 10'b00_0010_0000,
        ST_DIV  = 10'b00_0100_0000,
        ST_MH   = 10'b00_1000_0000,
        ST_ML   = 10'b01_0000_0000,
        ST_ACC  = 10'b10_0000_0000
    } state_t;

    localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

endpackage

// ===== rtl/short_range_repulsion_accumulator_unit.sv =====
// Top level of the short range repulsion accumulator with its iterative datapath.
// Begin, load and finish items are handled as they are accepted; a finish beat is held in the output
// register and the input is not ready until it is taken.
// A live near neighbor runs accept, setup, a squaring step per axis, 32 root steps, a check,
// then per axis a setup, 31 restoring division steps and 3 multiply/accumulate steps.
// Dead, unknown-type and far neighbors end at setup. Reset (aresetn low, synchronous)
// clears the config registers, position, force sum and all control state.
module short_range_repulsion_accumulator_unit #(
    parameter int NUM_CELL_TYPES = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic signed [31:0]   s_coord_a,
    input  logic signed [31:0]   s_coord_b,
    input  logic signed [31:0]   s_coord_c,
    input  logic [1:0]           s_kind,
    input  logic [30:0]          s_cell_radius,
    input  logic                 s_is_dead,
    input  logic signed [15:0]   s_jitter_x,
    input  logic signed [15:0]   s_jitter_y,
    input  logic signed [15:0]   s_jitter_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_force_x,
    output logic signed [31:0]   m_force_y,
    output logic signed [31:0]   m_force_z
);
    import srra_pkg::*;

    localparam int KW = (NUM_CELL_TYPES > 1) ? $clog2(NUM_CELL_TYPES) : 1;

    // Configuration registers, one per cell type.
    logic signed [31:0] spring_k_reg [NUM_CELL_TYPES];
    logic signed [31:0] reach_reg    [NUM_CELL_TYPES];

    // Architectural state.
    logic signed [31:0] pos_reg   [3];
    logic signed [31:0] force_reg [3];

    // Captured neighbor item.
    logic signed [31:0] coord_reg [3];
    logic signed [15:0] jit_reg   [3];
    logic [1:0]         kind_reg;
    logic [30:0]        radius_reg;
    logic               dead_reg;

    // Datapath registers.
    state_t       state_reg;
    logic [1:0]   idx_reg;
    logic [4:0]   cnt_reg;
    logic [30:0]  excl_reg;
    logic [30:0]  vmag_reg [3];
    logic         vneg_reg [3];
    logic         coinc_reg;
    logic         unit_dir_reg;
    logic [63:0]  acc_reg;
    logic [63:0]  x_reg;
    logic [33:0]  rem_reg;
    logic [31:0]  root_reg;
    logic [31:0]  len_reg;
    logic [31:0]  dist_reg;
    logic [45:0]  f_reg;
    logic [31:0]  drem_reg;
    logic         dbit_reg;
    logic [30:0]  q_reg;
    logic [53:0]  a_reg;
    logic [53:0]  b_reg;
    logic         m_valid_reg;
    logic signed [31:0] m_force_reg [3];

    // The config port never stalls; the user must write only while the block is idle, which it does not enforce.
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid   = m_valid_reg;
    assign m_force_x = m_force_reg[0];
    assign m_force_y = m_force_reg[1];
    assign m_force_z = m_force_reg[2];

    logic       s_beat;
    logic [2:0] cfg_reach_idx;
    assign s_beat        = s_valid && s_ready;
    assign cfg_reach_idx = cfg_index - CFG_REACH_BASE;

    // Neighbor setup: offsets, exclusion distance and the far test.
    logic signed [32:0] d_sig [3];
    logic [32:0]        d_mag [3];
    logic signed [31:0] reach_sel;
    logic [30:0]        excl_c;
    logic               far_c;
    logic               zero_d;
    logic               zero_j;
    logic               kind_ok;

    always_comb begin
        kind_ok   = ({30'd0, kind_reg} < NUM_CELL_TYPES);
        reach_sel = reach_reg[kind_reg[KW-1:0]];
        if ($signed({1'b0, radius_reg}) > reach_sel) begin
            excl_c = radius_reg;
        end else if (reach_sel < 32'sd1) begin
            excl_c = 31'd1;
        end else begin
            excl_c = reach_sel[30:0];
        end
        if (excl_c == 31'd0) begin
            excl_c = 31'd1;
        end
        far_c  = 1'b0;
        zero_d = 1'b1;
        zero_j = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d_sig[i] = $signed({pos_reg[i][31], pos_reg[i]})
                     - $signed({coord_reg[i][31], coord_reg[i]});
            d_mag[i] = d_sig[i][32] ? 33'(-d_sig[i]) : 33'(d_sig[i]);
            if (d_mag[i] >= {2'b00, excl_c}) begin
                far_c = 1'b1;
            end
            if (d_sig[i] != 33'sd0) begin
                zero_d = 1'b0;
            end
            if (jit_reg[i] != 16'sd0) begin
                zero_j = 1'b0;
            end
        end
    end

    // Shared arithmetic: squaring, square root step, division step, multiplies.
    logic [61:0] sq_prod;
    logic [35:0] sqrt_sh;
    logic [35:0] sqrt_trial;
    logic [32:0] div_sh;
    logic [30:0] k_pos;
    logic [30:0] overlap;
    logic [61:0] kf_prod;
    logic [54:0] low_sum;
    logic [46:0] contrib;
    logic signed [47:0] new_sum;
    logic signed [31:0] sat_sum;

    always_comb begin
        sq_prod    = 62'(vmag_reg[idx_reg]) * 62'(vmag_reg[idx_reg]);
        sqrt_sh    = {rem_reg, x_reg[63:62]};
        sqrt_trial = {2'b00, root_reg, 2'b01};
        div_sh     = {drem_reg, dbit_reg};
        k_pos      = spring_k_reg[kind_reg[KW-1:0]][31] ? 31'd0
                                                        : spring_k_reg[kind_reg[KW-1:0]][30:0];
        overlap    = excl_reg - dist_reg[30:0];
        kf_prod    = 62'(k_pos) * 62'(overlap);
        // floor(f * q / 2^30) from the two partial products.
        low_sum    = 55'({a_reg[6:0], 23'd0}) + 55'(b_reg);
        contrib    = 47'(a_reg[53:7]) + 47'(low_sum[54:30]);
        if (vneg_reg[idx_reg]) begin
            new_sum = 48'(force_reg[idx_reg]) - $signed({1'b0, contrib});
        end else begin
            new_sum = 48'(force_reg[idx_reg]) + $signed({1'b0, contrib});
        end
        if (new_sum > 48'sd2147483647) begin
            sat_sum = 32'sh7FFF_FFFF;
        end else if (new_sum < -48'sd2147483648) begin
            sat_sum = 32'sh8000_0000;
        end else begin
            sat_sum = new_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
            cnt_reg     <= 5'd0;
            for (int i = 0; i < NUM_CELL_TYPES; i++) begin
                spring_k_reg[i] <= 32'sd0;
                reach_reg[i]    <= 32'sd0;
            end
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]   <= 32'sd0;
                force_reg[i] <= 32'sd0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index < CFG_REACH_BASE) begin
                    if ({29'd0, cfg_index} < NUM_CELL_TYPES) begin
                        spring_k_reg[cfg_index[KW-1:0]] <= cfg_data;
                    end
                end else if (cfg_index < CFG_END) begin
                    if ({29'd0, cfg_reach_idx} < NUM_CELL_TYPES) begin
                        reach_reg[cfg_reach_idx[KW-1:0]] <= cfg_data;
                    end
                end
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        coord_reg[0] <= s_coord_a;
                        coord_reg[1] <= s_coord_b;
                        coord_reg[2] <= s_coord_c;
                        jit_reg[0]   <= s_jitter_x;
                        jit_reg[1]   <= s_jitter_y;
                        jit_reg[2]   <= s_jitter_z;
                        kind_reg     <= s_kind;
                        radius_reg   <= s_cell_radius;
                        dead_reg     <= s_is_dead;
                        unique case (func_t'(s_func))
                            FUNC_BEGIN: begin
                                pos_reg[0] <= s_coord_a;
                                pos_reg[1] <= s_coord_b;
                                pos_reg[2] <= s_coord_c;
                            end
                            FUNC_LOAD: begin
                                force_reg[0] <= s_coord_a;
                                force_reg[1] <= s_coord_b;
                                force_reg[2] <= s_coord_c;
                            end
                            FUNC_NEIGHBOR: begin
                                state_reg <= ST_PREP;
                            end
                            FUNC_FINISH: begin
                                m_valid_reg    <= 1'b1;
                                m_force_reg[0] <= force_reg[0];
                                m_force_reg[1] <= force_reg[1];
                                m_force_reg[2] <= force_reg[2];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_PREP: begin
                    excl_reg     <= excl_c;
                    coinc_reg    <= zero_d;
                    unit_dir_reg <= zero_d && zero_j;
                    acc_reg      <= 64'd0;
                    idx_reg      <= 2'd0;
                    for (int i = 0; i < 3; i++) begin
                        if (zero_d) begin
                            vmag_reg[i] <= 31'(jit_reg[i][15] ? 17'(-17'(jit_reg[i]))
                                                              : 17'(jit_reg[i]));
                            vneg_reg[i] <= jit_reg[i][15];
                        end else begin
                            vmag_reg[i] <= d_mag[i][30:0];
                            vneg_reg[i] <= d_sig[i][32];
                        end
                    end
                    if (dead_reg || !kind_ok || far_c) begin
                        state_reg <= ST_IDLE;
                    end else if (zero_d && zero_j) begin
                        // Default direction along x with distance one LSB.
                        dist_reg  <= 32'd1;
                        state_reg <= ST_CHK;
                    end else begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    acc_reg <= acc_reg + 64'(sq_prod);
                    if (idx_reg == 2'd2) begin
                        x_reg     <= acc_reg + 64'(sq_prod);
                        rem_reg   <= 34'd0;
                        root_reg  <= 32'd0;
                        cnt_reg   <= 5'd31;
                        state_reg <= ST_SQRT;
                    end else begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                ST_SQRT: begin
                    x_reg <= {x_reg[61:0], 2'b00};
                    if (sqrt_sh >= sqrt_trial) begin
                        rem_reg  <= 34'(sqrt_sh - sqrt_trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        rem_reg  <= sqrt_sh[33:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    if (cnt_reg == 5'd0) begin
                        len_reg   <= (sqrt_sh >= sqrt_trial) ? {root_reg[30:0], 1'b1}
                                                             : {root_reg[30:0], 1'b0};
                        dist_reg  <= coinc_reg ? 32'd1
                                   : ((sqrt_sh >= sqrt_trial) ? {root_reg[30:0], 1'b1}
                                                              : {root_reg[30:0], 1'b0});
                        state_reg <= ST_CHK;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                ST_CHK: begin
                    f_reg   <= kf_prod[61:16];
                    idx_reg <= 2'd0;
                    if (dist_reg >= {1'b0, excl_reg}) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_DIVI;
                    end
                end
                ST_DIVI: begin
                    if (unit_dir_reg) begin
                        q_reg     <= (idx_reg == 2'd0) ? UNIT_ONE : 31'd0;
                        state_reg <= ST_MH;
                    end else begin
                        drem_reg  <= {2'b00, vmag_reg[idx_reg][30:1]};
                        dbit_reg  <= vmag_reg[idx_reg][0];
                        q_reg     <= 31'd0;
                        cnt_reg   <= 5'd30;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    dbit_reg <= 1'b0;
                    if (div_sh >= {1'b0, len_reg}) begin
                        drem_reg <= 32'(div_sh - {1'b0, len_reg});
                        q_reg    <= {q_reg[29:0], 1'b1};
                    end else begin
                        drem_reg <= div_sh[31:0];
                        q_reg    <= {q_reg[29:0], 1'b0};
                    end
                    if (cnt_reg == 5'd0) begin
                        state_reg <= ST_MH;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                ST_MH: begin
                    a_reg     <= 54'(f_reg[45:23]) * 54'(q_reg);
                    state_reg <= ST_ML;
                end
                ST_ML: begin
                    b_reg     <= 54'(f_reg[22:0]) * 54'(q_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    force_reg[idx_reg] <= sat_sum;
                    if (idx_reg == 2'd2) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_DIVI;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/srra_checker.sv =====
// Port-level checker for the short range repulsion accumulator, with its bind.
module srra_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [1:0]          s_func,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [31:0]  m_force_x,
    input logic signed [31:0]  m_force_y,
    input logic signed [31:0]  m_force_z
);
    import srra_pkg::*;

    // A waiting result holds its value until taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_x)
                                && $stable(m_force_y) && $stable(m_force_z))
        else $error("result beat changed while stalled");

    // A finish beat produces a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_FINISH |=> m_valid)
        else $error("finish beat gave no result");

    // A neighbor beat keeps the input closed while it is worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_NEIGHBOR |=> !s_ready)
        else $error("input open during neighbor work");

    // No new beat is taken while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while a result waits");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind short_range_repulsion_accumulator_unit srra_checker u_srra_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_func    (s_func),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_force_x (m_force_x),
    .m_force_y (m_force_y),
    .m_force_z (m_force_z)
);
